// ===== src/ncl_pkg.sv =====
// ---------------------------------------------------------------------------
// ncl_pkg
// Shared widths, constants and state type for the chord length block.
// ---------------------------------------------------------------------------
`default_nettype none

package ncl_pkg;

   localparam int COORD_W        = 16;
   localparam int MAG_W          = 16;
   localparam int PROD_W         = 32;
   localparam int SQ_W           = 33;
   localparam int ROOT_W         = 17;
   localparam int LEN_W          = 23;
   localparam int FRAC_W         = 17;
   localparam int IDX_W          = 6;
   localparam int REQ_DATA_W     = 32;
   localparam int RSP_DATA_W     = 24;
   localparam int RSP_USER_W     = 2;
   localparam int MAX_POINTS_DEF = 64;

   localparam logic [LEN_W-1:0]  TOTAL_MAX = {LEN_W{1'b1}};
   localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_ROOT,
      S_READ,
      S_LOAD,
      S_DIV,
      S_PUSH
   } state_type;

endpackage

`default_nettype wire

// ===== src/ncl_squarer.sv =====
// ---------------------------------------------------------------------------
// ncl_squarer
// Bit-serial shift-add squarer for both coordinate deltas, then their sum.
// ---------------------------------------------------------------------------
`default_nettype none

module ncl_squarer (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [ncl_pkg::MAG_W-1:0]    mag_x,
   input  wire  [ncl_pkg::MAG_W-1:0]    mag_y,
   output logic                         done,
   output logic [ncl_pkg::SQ_W-1:0]     sum_sq
);

   localparam int STEPS = ncl_pkg::MAG_W;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic [ncl_pkg::MAG_W-1:0]     mx_ff, mx_in, my_ff, my_in;
   logic [ncl_pkg::PROD_W-1:0]    ax_ff, ax_in, ay_ff, ay_in;
   logic [ncl_pkg::PROD_W-1:0]    accx_ff, accx_in, accy_ff, accy_in;
   logic [ncl_pkg::SQ_W-1:0]      sum_ff, sum_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      accx_in = accx_ff;
      accy_in = accy_ff;
      sum_in  = sum_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mx_in   = mag_x;
         my_in   = mag_y;
         ax_in   = ncl_pkg::PROD_W'(mag_x);
         ay_in   = ncl_pkg::PROD_W'(mag_y);
         accx_in = '0;
         accy_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff == 5'(STEPS)) begin
            // final cycle adds the two squares
            sum_in  = {1'b0, accx_ff} + {1'b0, accy_ff};
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            accx_in = mx_ff[0] ? accx_ff + ax_ff : accx_ff;
            accy_in = my_ff[0] ? accy_ff + ay_ff : accy_ff;
            ax_in   = {ax_ff[ncl_pkg::PROD_W-2:0], 1'b0};
            ay_in   = {ay_ff[ncl_pkg::PROD_W-2:0], 1'b0};
            mx_in   = {1'b0, mx_ff[ncl_pkg::MAG_W-1:1]};
            my_in   = {1'b0, my_ff[ncl_pkg::MAG_W-1:1]};
            cnt_in  = cnt_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      accx_ff <= accx_in;
      accy_ff <= accy_in;
      sum_ff  <= sum_in;
   end

   assign done   = done_ff;
   assign sum_sq = sum_ff;

endmodule

`default_nettype wire

// ===== src/ncl_isqrt.sv =====
// ---------------------------------------------------------------------------
// ncl_isqrt
// Digit-serial integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ncl_isqrt (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [ncl_pkg::SQ_W-1:0]     radicand,
   output logic                         done,
   output logic [ncl_pkg::ROOT_W-1:0]   root
);

   localparam int STEPS = ncl_pkg::ROOT_W;
   localparam int RAD_W = 2 * ncl_pkg::ROOT_W;
   localparam int REM_W = ncl_pkg::ROOT_W + 2;
   localparam int CUR_W = REM_W + 2;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic [RAD_W-1:0]              rad_ff, rad_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [ncl_pkg::ROOT_W-1:0]    q_ff, q_in;
   logic [CUR_W-1:0]              cur, trial, diff;
   logic                          ge;

   always_comb begin
      cur   = {rem_ff, rad_ff[RAD_W-1:RAD_W-2]};
      trial = {2'b00, q_ff, 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = RAD_W'(radicand);
         rem_in  = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
         q_in   = {q_ff[ncl_pkg::ROOT_W-2:0], ge};
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign root = q_ff;

endmodule

`default_nettype wire

// ===== src/ncl_divider.sv =====
// ---------------------------------------------------------------------------
// ncl_divider
// Restoring divider for length over total, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ncl_divider (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [ncl_pkg::LEN_W-1:0]    numer,
   input  wire  [ncl_pkg::LEN_W-1:0]    denom,
   output logic                         done,
   output logic [ncl_pkg::FRAC_W-1:0]   quot
);

   localparam int STEPS = ncl_pkg::FRAC_W;
   localparam int REM_W = ncl_pkg::LEN_W + 1;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [ncl_pkg::LEN_W-1:0]     den_ff, den_in;
   logic [ncl_pkg::FRAC_W-1:0]    q_ff, q_in;
   logic [REM_W-1:0]              diff, kept;
   logic                          ge;

   always_comb begin
      ge   = (rem_ff >= {1'b0, den_ff});
      diff = rem_ff - {1'b0, den_ff};
      kept = ge ? diff : rem_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, numer};
         den_in  = denom;
         q_in    = '0;
      end else if (busy_ff) begin
         q_in   = {q_ff[ncl_pkg::FRAC_W-2:0], ge};
         rem_in = {kept[ncl_pkg::LEN_W-1:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

// ===== src/normalized_chord_length_parameterization.sv =====
// ---------------------------------------------------------------------------
// normalized_chord_length_parameterization
// Chord length parameterization of a 2-D polyline, normalized to Q1.16.
//
// Requests on req_ carry one signed Q8.8 point each; req_tlast marks the
// final point of a polyline. The first point of a run is stored directly,
// with length zero. Each further point passes through the bit-serial
// squarer, the one-bit-per-cycle square root and the length store write.
// Points beyond MAX_POINTS are dropped and flagged. After the last point,
// one result per stored point leaves on rsp_, in order; each passes
// through the length store read, the serial divider and the handoff to
// the output register. req_tready is high only between points and while
// no run is being emitted. Results sit in an output register, so the next
// division runs while the receiver stalls; emission pauses only when a new
// result is ready and the register is still full.
// Reset clears the run state and the output valid flag; the length store
// needs no clearing, since only entries written in the current run are read.
// ---------------------------------------------------------------------------
`default_nettype none

module normalized_chord_length_parameterization #(
   parameter int MAX_POINTS = ncl_pkg::MAX_POINTS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   // point_x, point_y
   input  wire  [ncl_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire                                req_tlast,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // point_index, fraction, zero pad
   output logic [ncl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // degenerate, truncated
   output logic [ncl_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int LEN_W  = ncl_pkg::LEN_W;

   ncl_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]                   count_ff, count_in;
   logic signed [ncl_pkg::COORD_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [LEN_W-1:0]                   total_ff, total_in;
   logic                               ovf_ff, ovf_in;
   logic                               last_ff, last_in;
   logic [ADDR_W-1:0]                  idx_ff, idx_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ncl_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [ncl_pkg::RSP_USER_W-1:0]     rsp_user_ff, rsp_user_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic [LEN_W-1:0]                   mem [MAX_POINTS];
   logic [LEN_W-1:0]                   rd_data_ff;
   logic                               mem_we;
   logic [ADDR_W-1:0]                  mem_addr;
   logic [LEN_W-1:0]                   mem_wdata;

   logic signed [ncl_pkg::COORD_W-1:0] pt_x, pt_y;
   logic signed [ncl_pkg::COORD_W:0]   dx, dy, ndx, ndy;
   logic [ncl_pkg::MAG_W-1:0]          mag_x, mag_y;
   logic                               accept, room, is_final, out_free;
   logic [LEN_W:0]                     total_sum;
   logic [ncl_pkg::FRAC_W-1:0]         frac;

   logic                               sq_start, sq_done;
   logic [ncl_pkg::SQ_W-1:0]           sq_sum;
   logic                               root_start, root_done;
   logic [ncl_pkg::ROOT_W-1:0]         root;
   logic                               div_start, div_done;
   logic [ncl_pkg::FRAC_W-1:0]         quot;

   ncl_squarer u_squarer (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .mag_x  (mag_x),
      .mag_y  (mag_y),
      .done   (sq_done),
      .sum_sq (sq_sum)
   );

   ncl_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sq_sum),
      .done     (root_done),
      .root     (root)
   );

   ncl_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (rd_data_ff),
      .denom (total_ff),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      pt_x      = req_tdata[15:0];
      pt_y      = req_tdata[31:16];
      dx        = {pt_x[15], pt_x} - {prev_x_ff[15], prev_x_ff};
      dy        = {pt_y[15], pt_y} - {prev_y_ff[15], prev_y_ff};
      ndx       = -dx;
      ndy       = -dy;
      mag_x     = dx[ncl_pkg::COORD_W] ? ndx[ncl_pkg::MAG_W-1:0] : dx[ncl_pkg::MAG_W-1:0];
      mag_y     = dy[ncl_pkg::COORD_W] ? ndy[ncl_pkg::MAG_W-1:0] : dy[ncl_pkg::MAG_W-1:0];
      accept    = req_tvalid && req_tready;
      room      = (count_ff < CNT_W'(MAX_POINTS));
      is_final  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
      out_free  = !rsp_valid_ff || rsp_tready;
      total_sum = {1'b0, total_ff} + (LEN_W + 1)'(root);
      frac      = (total_ff == '0) ? '0 : quot;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ncl_pkg::S_IDLE: begin
            if (accept) begin
               if (room && count_ff != '0) begin
                  state_in = ncl_pkg::S_SQUARE;
               end else if (req_tlast) begin
                  state_in = ncl_pkg::S_READ;
               end
            end
         end
         ncl_pkg::S_SQUARE: begin
            if (sq_done) begin
               state_in = ncl_pkg::S_ROOT;
            end
         end
         ncl_pkg::S_ROOT: begin
            if (root_done) begin
               state_in = last_ff ? ncl_pkg::S_READ : ncl_pkg::S_IDLE;
            end
         end
         ncl_pkg::S_READ: begin
            state_in = ncl_pkg::S_LOAD;
         end
         ncl_pkg::S_LOAD: begin
            state_in = ncl_pkg::S_DIV;
         end
         ncl_pkg::S_DIV: begin
            if (div_done) begin
               state_in = ncl_pkg::S_PUSH;
            end
         end
         ncl_pkg::S_PUSH: begin
            if (out_free) begin
               state_in = is_final ? ncl_pkg::S_IDLE : ncl_pkg::S_READ;
            end
         end
         default: begin
            state_in = ncl_pkg::S_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready   = 1'b0;
      sq_start     = 1'b0;
      root_start   = 1'b0;
      div_start    = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = count_ff[ADDR_W-1:0];
      mem_wdata    = '0;
      count_in     = count_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ncl_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               last_in = req_tlast;
               idx_in  = '0;
               if (room) begin
                  prev_x_in = pt_x;
                  prev_y_in = pt_y;
                  if (count_ff == '0) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     sq_start = 1'b1;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ncl_pkg::S_SQUARE: begin
            root_start = sq_done;
         end
         ncl_pkg::S_ROOT: begin
            if (root_done) begin
               total_in  = total_sum[LEN_W] ? ncl_pkg::TOTAL_MAX : total_sum[LEN_W-1:0];
               mem_we    = 1'b1;
               mem_wdata = total_in;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         ncl_pkg::S_READ: begin
         end
         ncl_pkg::S_LOAD: begin
            div_start = 1'b1;
         end
         ncl_pkg::S_DIV: begin
         end
         ncl_pkg::S_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, frac, ncl_pkg::IDX_W'(idx_ff)};
               rsp_user_in  = {ovf_ff, (total_ff == '0)};
               rsp_last_in  = is_final;
               if (is_final) begin
                  count_in  = '0;
                  prev_x_in = '0;
                  prev_y_in = '0;
                  total_in  = '0;
                  ovf_in    = 1'b0;
                  idx_in    = '0;
               end else begin
                  idx_in = idx_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ncl_pkg::S_IDLE;
         count_ff     <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   // length store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_degenerate_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[22:6] == '0)
      else $error("degenerate result with nonzero fraction");

   a_frac_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:6] <= ncl_pkg::FRAC_ONE)
      else $error("fraction above one");

   a_last_is_one : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && !rsp_tuser[0] |-> rsp_tdata[22:6] == ncl_pkg::FRAC_ONE)
      else $error("final point fraction is not one");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond capacity");

endmodule

`default_nettype wire
